// ===== hdl/desp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// desp_pkg
// Shared types, constants and command/status structs of the shortest path block.
// ----------------------------------------------------------------------------
package desp_pkg;

  localparam int MaxWaypoints = 1024;
  localparam int CoordBits    = 14;
  localparam int DistBits     = 48;
  localparam int NodeMax      = MaxWaypoints + 2;
  localparam int IdxBits      = $clog2(MaxWaypoints);       // waypoint address
  localparam int CntBits      = $clog2(MaxWaypoints + 1);   // waypoint count
  localparam int NodeBits     = $clog2(NodeMax + 1);        // node id, may hold NodeMax

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [DistBits-1:0]  dist_t;
  typedef logic [NodeBits-1:0]  node_t;
  typedef logic [CntBits-1:0]   cnt_t;
  typedef logic [IdxBits-1:0]   idx_t;

  localparam dist_t DistLimit = '1;

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_ADD   = 3'd1,
    MODE_START = 3'd2,
    MODE_END   = 3'd3,
    MODE_SOLVE = 3'd4,
    MODE_READ  = 3'd5
  } mode_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,      // write dist/parent/visited of node cnt
    OP_SCAN_RD,   // issue memory read of node cnt (scan)
    OP_SCAN_CMP,  // compare data of node cnt with best
    OP_MARK_RD,   // present best node to the point stores
    OP_MARK,      // mark best visited, latch its distance and point
    OP_RELAX_RD,  // read node cnt and its point
    OP_RELAX_WT,  // compute weight
    OP_RELAX_WR,  // compare and write back
    OP_WALK_RD,   // read parent of cur
    OP_WALK_ST,   // step cur, maybe store waypoint
    OP_REV_RD,    // read both ends of the path
    OP_REV_WR     // swap
  } op_e;

  typedef struct packed {
    op_e   op;
    node_t cnt;   // node / element counter driven by controller
    cnt_t  aux;   // second index (reverse)
  } dp_cmd_t;

  typedef struct packed {
    logic  found;     // scan found an unvisited node
    logic  walk_stop; // parent chain ended
    cnt_t  len;       // path length gathered so far
    cnt_t  count;     // waypoint count
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/desp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// desp_in_if / desp_out_if
// Valid/ready channels carrying load/solve/read items and read results.
// ----------------------------------------------------------------------------
interface desp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [13:0] coord_x;
  logic [13:0] coord_y;
  modport source (output valid, mode, coord_x, coord_y, input ready);
  modport sink   (input valid, mode, coord_x, coord_y, output ready);
endinterface

interface desp_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] waypoint_index;
  logic       last_of_path;
  logic       direct_route;
  logic       past_end;
  logic       overflowed;
  modport source (output valid, waypoint_index, last_of_path, direct_route, past_end,
                  overflowed, input ready);
  modport sink   (input valid, waypoint_index, last_of_path, direct_route, past_end,
                  overflowed, output ready);
endinterface
`default_nettype wire

// ===== hdl/desp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// desp_datapath
// Point stores, node scratch memories, weight unit and path buffer.
// ----------------------------------------------------------------------------
module desp_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  desp_pkg::dp_cmd_t   cmd_i,
  input  wire                 load_i,     // accepted load item
  input  wire  [2:0]          mode_i,
  input  desp_pkg::coord_t    x_i,
  input  desp_pkg::coord_t    y_i,
  input  wire                 read_i,     // produce read answer into out regs
  input  wire                 solve_done_i,
  output desp_pkg::dp_sts_t   sts_o,
  output logic [9:0]          r_idx_o,
  output logic                r_last_o,
  output logic                r_direct_o,
  output logic                r_past_o,
  output logic                r_ovf_o
);
  import desp_pkg::*;

  // point stores
  coord_t wx_mem [MaxWaypoints];
  coord_t wy_mem [MaxWaypoints];
  coord_t sx_q, sy_q, ex_q, ey_q;
  cnt_t   count_q;
  logic   ovf_q;

  // node scratch
  dist_t  dist_mem [NodeMax];
  node_t  par_mem  [NodeMax];
  logic   vis_mem  [NodeMax];
  idx_t   path_mem [MaxWaypoints];

  cnt_t   plen_q, rpos_q, len_q;
  dist_t  best_d_q, du_q, rd_d_q;
  node_t  best_q, u_q, cur_q, rd_p_q;
  logic   rd_v_q, found_q, stop_q;
  coord_t ux_q, uy_q, wxr_q, wyr_q;
  coord_t pt_x, pt_y;
  dist_t  w_q;
  idx_t   pa_q, pb_q;
  logic [2*CoordBits-1:0] sqx_q, sqy_q;

  node_t nodes;
  assign nodes = node_t'(count_q) + node_t'(2);

  // node point select from registered store reads
  node_t rd_node_q;
  node_t rd_addr;
  assign rd_addr = (cmd_i.op == OP_MARK_RD) ? best_q : cmd_i.cnt;

  always_ff @(posedge clk_i) begin
    wxr_q <= wx_mem[idx_t'(rd_addr - node_t'(1))];
    wyr_q <= wy_mem[idx_t'(rd_addr - node_t'(1))];
  end

  always_comb begin
    if (rd_node_q == '0) begin
      pt_x = sx_q; pt_y = sy_q;
    end else if (rd_node_q <= node_t'(count_q)) begin
      pt_x = wxr_q; pt_y = wyr_q;
    end else begin
      pt_x = ex_q; pt_y = ey_q;
    end
  end

  coord_t ddx, ddy;
  assign ddx = (ux_q > pt_x) ? ux_q - pt_x : pt_x - ux_q;
  assign ddy = (uy_q > pt_y) ? uy_q - pt_y : pt_y - uy_q;

  logic [DistBits:0] wsum, csum;
  assign wsum = {1'b0, dist_t'(sqx_q)} + {1'b0, dist_t'(sqy_q)};
  assign csum = {1'b0, du_q} + {1'b0, w_q};
  dist_t cand;
  assign cand = csum[DistBits] ? DistLimit : csum[DistBits-1:0];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0; sy_q <= '0; ex_q <= '0; ey_q <= '0;
      count_q <= '0; ovf_q <= 1'b0; plen_q <= '0; rpos_q <= '0;
      len_q <= '0; found_q <= 1'b0; stop_q <= 1'b0;
      best_q <= '0; cur_q <= '0; u_q <= '0; rd_node_q <= '0;
    end else begin
      rd_node_q <= rd_addr;
      if (load_i) begin
        unique case (mode_i)
          MODE_CLEAR: begin
            count_q <= '0; ovf_q <= 1'b0; plen_q <= '0; rpos_q <= '0;
          end
          MODE_ADD: begin
            if (count_q < cnt_t'(MaxWaypoints)) count_q <= count_q + cnt_t'(1);
            else ovf_q <= 1'b1;
          end
          MODE_START: begin sx_q <= x_i; sy_q <= y_i; end
          MODE_END:   begin ex_q <= x_i; ey_q <= y_i; end
          default: ;
        endcase
      end
      if (read_i) begin
        if (plen_q == '0) begin
          if (rpos_q == '0) rpos_q <= cnt_t'(1);
        end else if (rpos_q < plen_q) begin
          rpos_q <= rpos_q + cnt_t'(1);
        end
      end
      if (solve_done_i) begin
        plen_q <= len_q; rpos_q <= '0;
      end
      unique case (cmd_i.op)
        OP_INIT: begin
          found_q <= 1'b0; len_q <= '0; stop_q <= 1'b0;
          cur_q <= nodes - node_t'(1);
        end
        OP_SCAN_RD: ;
        OP_SCAN_CMP: begin
          if (!rd_v_q && (!found_q || rd_d_q < best_d_q)) begin
            found_q <= 1'b1; best_q <= rd_node_q;
          end
        end
        OP_MARK: begin
          u_q <= best_q; found_q <= 1'b0;
        end
        OP_WALK_ST: begin
          if (rd_p_q == cur_q || rd_p_q >= nodes) stop_q <= 1'b1;
          else begin
            cur_q <= rd_p_q;
            if (rd_p_q >= node_t'(1) && rd_p_q <= node_t'(count_q)
                && len_q < cnt_t'(MaxWaypoints))
              len_q <= len_q + cnt_t'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload and memories
  always_ff @(posedge clk_i) begin
    if (load_i && mode_i == MODE_ADD && count_q < cnt_t'(MaxWaypoints)) begin
      wx_mem[idx_t'(count_q)] <= x_i;
      wy_mem[idx_t'(count_q)] <= y_i;
    end
    rd_d_q <= dist_mem[cmd_i.cnt];
    rd_v_q <= vis_mem[cmd_i.cnt];
    rd_p_q <= par_mem[(cmd_i.op == OP_WALK_RD) ? cur_q : cmd_i.cnt];
    // port A serves the read answer while the sequencer is idle
    pa_q   <= path_mem[(cmd_i.op == OP_NONE) ? idx_t'(rpos_q) : idx_t'(cmd_i.cnt)];
    pb_q   <= path_mem[idx_t'(cmd_i.aux)];
    sqx_q  <= ddx * ddx;
    sqy_q  <= ddy * ddy;
    unique case (cmd_i.op)
      OP_INIT: begin
        dist_mem[cmd_i.cnt] <= (cmd_i.cnt == '0) ? '0 : DistLimit;
        par_mem[cmd_i.cnt]  <= cmd_i.cnt;
        vis_mem[cmd_i.cnt]  <= 1'b0;
      end
      OP_SCAN_CMP: begin
        if (!rd_v_q && (!found_q || rd_d_q < best_d_q)) best_d_q <= rd_d_q;
      end
      OP_MARK: begin
        vis_mem[best_q] <= 1'b1;
        du_q <= best_d_q;
        ux_q <= pt_x; uy_q <= pt_y;
      end
      OP_RELAX_WT: w_q <= wsum[DistBits] ? DistLimit : wsum[DistBits-1:0];
      OP_RELAX_WR: begin
        if (!rd_v_q && cand != DistLimit && cand < rd_d_q) begin
          dist_mem[rd_node_q] <= cand;
          par_mem[rd_node_q]  <= u_q;
        end
      end
      OP_WALK_ST: begin
        if (!(rd_p_q == cur_q || rd_p_q >= nodes) && rd_p_q >= node_t'(1)
            && rd_p_q <= node_t'(count_q) && len_q < cnt_t'(MaxWaypoints))
          path_mem[idx_t'(len_q)] <= idx_t'(rd_p_q - node_t'(1));
      end
      OP_REV_WR: begin
        path_mem[idx_t'(cmd_i.cnt)] <= pb_q;
        path_mem[idx_t'(cmd_i.aux)] <= pa_q;
      end
      default: ;
    endcase
  end

  // read answer, combinational on registered state (taken by top on read_i)
  always_comb begin
    r_idx_o = '0; r_last_o = 1'b0; r_direct_o = 1'b0; r_past_o = 1'b0;
    if (plen_q == '0) begin
      if (rpos_q == '0) begin r_direct_o = 1'b1; r_last_o = 1'b1; end
      else r_past_o = 1'b1;
    end else if (rpos_q < plen_q) begin
      r_idx_o  = 10'(pa_q);
      r_last_o = (rpos_q + cnt_t'(1) == plen_q);
    end else r_past_o = 1'b1;
    r_ovf_o = ovf_q;
  end

  assign sts_o.found     = found_q;
  assign sts_o.walk_stop = stop_q;
  assign sts_o.len       = len_q;
  assign sts_o.count     = count_q;

endmodule
`default_nettype wire

// ===== hdl/desp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// desp_ctrl
// Sequencer of the solve: init sweep, scan/mark/relax rounds, walk, reverse.
// ----------------------------------------------------------------------------
module desp_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  desp_pkg::dp_sts_t  sts_i,
  output desp_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               done_o
);
  import desp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SCAN_RD, S_SCAN_CMP, S_MARK, S_MARK2,
    S_RX_RD, S_RX_WT0, S_RX_WT, S_RX_WR, S_WALK_RD, S_WALK_ST,
    S_REV_RD, S_REV_WR, S_DONE
  } state_e;

  state_e state_q;
  node_t  cnt_q, steps_q;
  cnt_t   aux_q;
  node_t  nodes;
  assign nodes = node_t'(sts_i.count) + node_t'(2);

  always_comb begin
    cmd_o.cnt = cnt_q;
    cmd_o.aux = aux_q;
    unique case (state_q)
      S_INIT:     cmd_o.op = OP_INIT;
      S_SCAN_RD:  cmd_o.op = OP_SCAN_RD;
      S_SCAN_CMP: cmd_o.op = OP_SCAN_CMP;
      S_MARK:     cmd_o.op = OP_MARK_RD;
      S_MARK2:    cmd_o.op = OP_MARK;
      S_RX_RD:    cmd_o.op = OP_RELAX_RD;
      S_RX_WT:    cmd_o.op = OP_RELAX_WT;
      S_RX_WR:    cmd_o.op = OP_RELAX_WR;
      S_WALK_RD:  cmd_o.op = OP_WALK_RD;
      S_WALK_ST:  cmd_o.op = OP_WALK_ST;
      S_REV_RD:   cmd_o.op = OP_REV_RD;
      S_REV_WR:   cmd_o.op = OP_REV_WR;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  // cnt_q doubles as the memory address; it is held steady over the
  // read, compare and write states of one element.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; aux_q <= '0; steps_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (start_i) begin state_q <= S_INIT; cnt_q <= '0; end
        S_INIT: begin
          if (cnt_q == nodes - node_t'(1)) begin
            cnt_q <= '0; state_q <= S_SCAN_RD;
          end else cnt_q <= cnt_q + node_t'(1);
        end
        S_SCAN_RD:  state_q <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (cnt_q == nodes - node_t'(1)) state_q <= S_MARK;
          else begin cnt_q <= cnt_q + node_t'(1); state_q <= S_SCAN_RD; end
        end
        S_MARK: begin
          // present best node address so its point comes out of the store
          if (!sts_i.found) begin
            state_q <= S_WALK_RD; steps_q <= '0;
          end else state_q <= S_MARK2;
          cnt_q <= '0;
        end
        S_MARK2: begin cnt_q <= '0; state_q <= S_RX_RD; end
        S_RX_RD:  state_q <= S_RX_WT0;
        S_RX_WT0: state_q <= S_RX_WT;
        S_RX_WT:  state_q <= S_RX_WR;
        S_RX_WR: begin
          if (cnt_q == nodes - node_t'(1)) begin
            cnt_q <= '0; state_q <= S_SCAN_RD;
          end else begin cnt_q <= cnt_q + node_t'(1); state_q <= S_RX_RD; end
        end
        S_WALK_RD: state_q <= S_WALK_ST;
        S_WALK_ST: begin
          if (steps_q == nodes - node_t'(1) || sts_i.walk_stop) begin
            cnt_q <= '0; aux_q <= sts_i.len - cnt_t'(1); state_q <= S_REV_RD;
          end else begin
            steps_q <= steps_q + node_t'(1); state_q <= S_WALK_RD;
          end
        end
        S_REV_RD: begin
          if (cnt_t'(cnt_q) >= aux_q || sts_i.len == '0) state_q <= S_DONE;
          else state_q <= S_REV_WR;
        end
        S_REV_WR: begin
          cnt_q <= cnt_q + node_t'(1); aux_q <= aux_q - cnt_t'(1); state_q <= S_REV_RD;
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_done_from_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> $past(state_q) == S_REV_RD) else $error("done without reverse");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && state_q == S_IDLE |=> state_q == S_INIT) else $error("solve not started");
  a_wr_after_wt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RX_WR |-> $past(state_q) == S_RX_WT) else $error("relax order");

endmodule
`default_nettype wire

// ===== hdl/dense_euclid_shortest_path.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dense_euclid_shortest_path
// Shortest path over start, end and waypoints with squared Euclidean weights.
// ----------------------------------------------------------------------------
// Usage: items enter on in_ch (mode, coord_x, coord_y). Modes clear, add,
// set start and set end take effect on acceptance. For a read, the item is
// accepted, the answer is registered on out_ch and held until taken; no new
// item is accepted while an answer waits. Solve runs on a sequencer over the
// node memories: an init sweep over N nodes, then per round a scan of N
// nodes, a mark and a relax of N nodes (N rounds plus a last round that
// only scans), then the walk steps and the swaps, N = count+2. After reset
// the stores are empty, start and end are at the origin and a read answers
// direct route. Stalling the receiver holds the answer register and so
// blocks new items.
// ----------------------------------------------------------------------------
module dense_euclid_shortest_path (
  input  wire        clk_i,
  input  wire        rst_ni,
  desp_in_if.sink    in_ch,
  desp_out_if.source out_ch
);
  import desp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic busy, done, acc, rd_pend_q, ovalid_q;
  logic [9:0] r_idx;
  logic r_last, r_dir, r_past, r_ovf;

  assign in_ch.ready = !busy && !ovalid_q && !rd_pend_q;
  assign acc = in_ch.valid && in_ch.ready;

  desp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(acc && in_ch.mode == MODE_SOLVE),
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy), .done_o(done)
  );

  desp_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .load_i(acc), .mode_i(in_ch.mode),
    .x_i(in_ch.coord_x), .y_i(in_ch.coord_y),
    .read_i(rd_pend_q), .solve_done_i(done), .sts_o(sts),
    .r_idx_o(r_idx), .r_last_o(r_last), .r_direct_o(r_dir),
    .r_past_o(r_past), .r_ovf_o(r_ovf)
  );

  // path buffer read data is registered, so the answer forms in the cycle after the read is accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      rd_pend_q <= acc && in_ch.mode == MODE_READ;
      if (rd_pend_q) ovalid_q <= 1'b1;
      else if (out_ch.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      out_ch.waypoint_index <= r_idx;
      out_ch.last_of_path   <= r_last;
      out_ch.direct_route   <= r_dir;
      out_ch.past_end       <= r_past;
      out_ch.overflowed     <= r_ovf;
    end
  end
  assign out_ch.valid = ovalid_q;

  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !acc) else $error("accept while solving");
  a_read_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |=> ovalid_q) else $error("read answer lost");
  a_one_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> !rd_pend_q) else $error("answer overwritten");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dense_euclid_shortest_path.
// Loads random point sets and solves them. Read answers are checked against a
// behavioral route solver kept in step with every accepted transaction.
// Both sides idle at random, and there is one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import desp_pkg::*;

  localparam logic [2:0] ModeSpareLo = 3'd6;
  localparam logic [2:0] ModeSpareHi = 3'd7;
  localparam longint unsigned RouteInf = (64'd1 << DistBits) - 64'd1;
  localparam int IdleLimit = 2000000;
  localparam int LongHold  = 400;
  localparam int RandItems = 1700;

  typedef struct packed {
    logic [2:0] mode;
    coord_t     x;
    coord_t     y;
  } cmd_t;

  typedef struct packed {
    logic [9:0] wp_idx;
    logic       last;
    logic       direct;
    logic       past;
    logic       ovf;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  desp_in_if  in_ch();
  desp_out_if out_ch();

  dense_euclid_shortest_path u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  cmd_t    cmd_queue[$];
  answer_t answer_queue[$];
  int      error_count = 0;

  // ---- route model state --------------------------------------------------
  coord_t wp_x[MaxWaypoints];
  coord_t wp_y[MaxWaypoints];
  coord_t start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  int     wp_count = 0;
  bit     wp_dropped = 1'b0;
  int     route_q[$];
  int     read_pos = 0;

  function automatic void node_point(int n, output coord_t px, output coord_t py);
    if (n == 0) begin
      px = start_x; py = start_y;
    end else if (n <= wp_count) begin
      px = wp_x[n-1]; py = wp_y[n-1];
    end else begin
      px = end_x; py = end_y;
    end
  endfunction

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > RouteInf) ? RouteInf : s;
  endfunction

  function automatic longint unsigned sq_dist(int a, int b);
    coord_t ax, ay, bx, by;
    longint unsigned dx, dy;
    node_point(a, ax, ay);
    node_point(b, bx, by);
    dx = (ax > bx) ? longint'(ax - bx) : longint'(bx - ax);
    dy = (ay > by) ? longint'(ay - by) : longint'(by - ay);
    return sat_sum(dx * dx, dy * dy);
  endfunction

  function automatic void solve_route();
    longint unsigned node_dist[NodeMax];
    int parent[NodeMax];
    bit seen[NodeMax];
    int nodes, u, cur, p;
    longint unsigned cand;
    nodes = wp_count + 2;
    for (int i = 0; i < nodes; i++) begin
      node_dist[i] = RouteInf; parent[i] = i; seen[i] = 1'b0;
    end
    node_dist[0] = 0;
    for (int r = 0; r < nodes; r++) begin
      u = nodes;
      for (int i = 0; i < nodes; i++)
        if (!seen[i] && (u == nodes || node_dist[i] < node_dist[u])) u = i;
      if (u == nodes) break;
      seen[u] = 1'b1;
      for (int i = 0; i < nodes; i++) begin
        if (seen[i]) continue;
        cand = sat_sum(node_dist[u], sq_dist(u, i));
        if (cand < node_dist[i]) begin
          node_dist[i] = cand; parent[i] = u;
        end
      end
    end
    route_q.delete();
    cur = nodes - 1;
    for (int s = 0; s < nodes; s++) begin
      p = parent[cur];
      if (p == cur || p >= nodes) break;
      cur = p;
      if (cur >= 1 && cur <= wp_count && route_q.size() < MaxWaypoints)
        route_q.push_front(cur - 1);
    end
    read_pos = 0;
  endfunction

  function automatic void route_model_step(cmd_t c);
    answer_t a;
    case (c.mode)
      MODE_CLEAR: begin
        wp_count = 0; wp_dropped = 1'b0; route_q.delete(); read_pos = 0;
      end
      MODE_ADD: begin
        if (wp_count < MaxWaypoints) begin
          wp_x[wp_count] = c.x; wp_y[wp_count] = c.y; wp_count++;
        end else begin
          wp_dropped = 1'b1;
        end
      end
      MODE_START: begin start_x = c.x; start_y = c.y; end
      MODE_END:   begin end_x = c.x; end_y = c.y; end
      MODE_SOLVE: solve_route();
      MODE_READ: begin
        a = '0;
        if (route_q.size() == 0) begin
          if (read_pos == 0) begin
            a.direct = 1'b1; a.last = 1'b1; read_pos = 1;
          end else begin
            a.past = 1'b1;
          end
        end else if (read_pos < route_q.size()) begin
          a.wp_idx = route_q[read_pos];
          a.last = (read_pos + 1 == route_q.size());
          read_pos++;
        end else begin
          a.past = 1'b1;
        end
        a.ovf = wp_dropped;
        answer_queue.insert(answer_queue.size(), a);
      end
      default: ;
    endcase
  endfunction

  // ---- stimulus -----------------------------------------------------------
  int gen_count = 0;

  function automatic void add_cmd(logic [2:0] m, coord_t x, coord_t y);
    cmd_t c;
    c.mode = m;
    c.x = x;
    c.y = y;
    cmd_queue.insert(cmd_queue.size(), c);
  endfunction

  // spread: full range, tight cluster (ties), or the corners
  function automatic coord_t rand_coord(int kind);
    case (kind)
      0: return coord_t'($urandom_range(0, 16383));
      1: return coord_t'($urandom_range(0, 7));
      default: return $urandom_range(0, 1) ? coord_t'(16383) : coord_t'(0);
    endcase
  endfunction

  task automatic random_scenario();
    int k, kind;
    kind = $urandom_range(0, 2);
    if ($urandom_range(0, 3) != 0 || gen_count > 60) begin
      add_cmd(MODE_CLEAR, coord_t'($urandom), coord_t'($urandom));
      gen_count = 0;
    end
    if ($urandom_range(0, 1)) add_cmd(MODE_START, rand_coord(kind), rand_coord(kind));
    if ($urandom_range(0, 1)) add_cmd(MODE_END, rand_coord(kind), rand_coord(kind));
    k = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    for (int i = 0; i < k; i++) begin
      add_cmd(MODE_ADD, rand_coord(kind), rand_coord(kind));
      if ($urandom_range(0, 19) == 0)
        add_cmd($urandom_range(0, 1) ? ModeSpareHi : ModeSpareLo,
                coord_t'($urandom), coord_t'($urandom));
    end
    gen_count += k;
    if ($urandom_range(0, 9) != 0) add_cmd(MODE_SOLVE, '0, '0);
    k = $urandom_range(0, gen_count + 2);
    for (int i = 0; i < k; i++) begin
      add_cmd(MODE_READ, coord_t'($urandom), coord_t'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        add_cmd(MODE_ADD, rand_coord(0), rand_coord(0));
        gen_count++;
      end
    end
  endtask

  task automatic build_stimulus();
    // directed: empty path, corner points, ignored modes, ties, clear
    add_cmd(MODE_READ, '0, '0);
    add_cmd(MODE_READ, '1, '1);
    add_cmd(MODE_START, '0, '0);
    add_cmd(MODE_END, 14'd16383, 14'd16383);
    add_cmd(MODE_SOLVE, '0, '0);
    add_cmd(MODE_READ, '0, '0);
    add_cmd(MODE_ADD, 14'd8191, 14'd8191);
    add_cmd(MODE_ADD, 14'd16383, 14'd0);
    add_cmd(MODE_ADD, 14'd0, 14'd16383);
    add_cmd(ModeSpareLo, 14'd16383, 14'd16383);
    add_cmd(ModeSpareHi, 14'd10922, 14'd5461);
    add_cmd(MODE_SOLVE, '0, '0);
    add_cmd(MODE_READ, '0, '0);
    add_cmd(MODE_READ, '0, '0);
    add_cmd(MODE_ADD, 14'd8191, 14'd8191);
    add_cmd(MODE_READ, '0, '0);
    add_cmd(MODE_SOLVE, '0, '0);
    add_cmd(MODE_READ, '0, '0);
    add_cmd(MODE_READ, '0, '0);
    add_cmd(MODE_READ, '0, '0);
    add_cmd(MODE_CLEAR, '0, '0);
    add_cmd(MODE_READ, '0, '0);
    add_cmd(MODE_READ, '0, '0);
    // capacity: one add too many, read the flag, then clear before any solve
    add_cmd(MODE_CLEAR, '0, '0);
    for (int i = 0; i <= MaxWaypoints; i++) add_cmd(MODE_ADD, rand_coord(0), rand_coord(0));
    add_cmd(MODE_READ, '0, '0);
    add_cmd(MODE_ADD, '1, '1);
    add_cmd(MODE_READ, '0, '0);
    add_cmd(MODE_CLEAR, '0, '0);
    add_cmd(MODE_READ, '0, '0);
    gen_count = 0;
    while (cmd_queue.size() < RandItems) random_scenario();
    add_cmd(MODE_SOLVE, '0, '0);
    add_cmd(MODE_READ, '0, '0);
  endtask

  // ---- driver -------------------------------------------------------------
  int  drv_gap = 0;
  bit  drv_burst = 1'b0;
  cmd_t next_cmd;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= '0;
      in_ch.coord_x <= '0;
      in_ch.coord_y <= '0;
      drv_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        route_model_step('{mode: in_ch.mode, x: in_ch.coord_x, y: in_ch.coord_y});
      if (!in_ch.valid || in_ch.ready) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          next_cmd = cmd_queue.pop_front();
          in_ch.mode <= next_cmd.mode;
          in_ch.coord_x <= next_cmd.x;
          in_ch.coord_y <= next_cmd.y;
          in_ch.valid <= 1'b1;
          if ($urandom_range(0, 63) == 0) drv_burst = !drv_burst;
          drv_gap <= drv_burst ? 0 : $urandom_range(0, 3);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor and checker ------------------------------------------------
  int      mon_stall = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  int      answers_seen = 0;
  answer_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        answers_seen++;
        if (answer_queue.size() == 0) begin
          $error("unexpected read answer, index %0d", out_ch.waypoint_index);
          error_count++;
        end else begin
          want = answer_queue.pop_front();
          if (out_ch.waypoint_index !== want.wp_idx) begin
            $error("waypoint_index: expected %0d, got %0d", want.wp_idx,
                   out_ch.waypoint_index);
            error_count++;
          end
          if (out_ch.last_of_path !== want.last) begin
            $error("last_of_path: expected %0b, got %0b", want.last, out_ch.last_of_path);
            error_count++;
          end
          if (out_ch.direct_route !== want.direct) begin
            $error("direct_route: expected %0b, got %0b", want.direct, out_ch.direct_route);
            error_count++;
          end
          if (out_ch.past_end !== want.past) begin
            $error("past_end: expected %0b, got %0b", want.past, out_ch.past_end);
            error_count++;
          end
          if (out_ch.overflowed !== want.ovf) begin
            $error("overflowed: expected %0b, got %0b", want.ovf, out_ch.overflowed);
            error_count++;
          end
        end
        mon_stall = $urandom_range(0, 3);
        if (answers_seen == 40 && !hold_done) begin
          hold_left = LongHold;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (mon_stall > 0) begin
        mon_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---- watchdog -----------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    out_ch.ready = 1'b0;
    build_stimulus();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (cmd_queue.size() != 0 || in_ch.valid || answer_queue.size() != 0);
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && answer_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/desp_pkg.sv
hdl/desp_if.sv
hdl/desp_datapath.sv
hdl/desp_ctrl.sv
hdl/dense_euclid_shortest_path.sv
test/tb.sv
